[rtl/core/ovl_pkg.sv]
// Package for the ordered value list: sizes, action codes and cell control types.
// Used by every module under rtl/core; depends on nothing else.

package ovl_pkg;

	// List capacity and the widths that follow from it.
	localparam int CAPACITY = 16;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int DATA_W   = 32;
	localparam int ACT_W    = 3;

	// Action codes carried by an input item.
	typedef enum logic [ACT_W-1:0] {
		ACT_APPEND = 3'd0,
		ACT_INSERT = 3'd1,
		ACT_FIND   = 3'd2,
		ACT_READ   = 3'd3,
		ACT_RESIZE = 3'd4
	} act_t;

	// What a cell does with its entry at the next clock edge.
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_SHIFT,
		CELL_ZERO
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
	} cell_ctrl_t;

endpackage

[rtl/core/ordered_value_list.sv]
// Top level of the ordered value list: a row of cells, the per-cell control and the result register.
// Depends on ovl_pkg, ovl_cell and ovl_find.
//
//  Channel  | Handshake          | Fields
//  ---------+--------------------+---------------------------------------------
//  command  | start / busy       | action, position, value, new_length
//  result   | done (one cycle)   | ok, found, found_index, read_value, length
//
// All cells compare and shift in parallel at the accept edge,
// so busy stays low and a new item may follow in every cycle.
// The result appears with done in the cycle after the accept edge and lasts one cycle.
// Reset empties the list; the cell entries themselves are not cleared.
// The receiver cannot stall, so no result is ever held back.

module ordered_value_list (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [ovl_pkg::ACT_W-1:0]  action,
	input  logic [ovl_pkg::CNT_W-1:0]  position,
	input  logic [ovl_pkg::DATA_W-1:0] value,
	input  logic [ovl_pkg::CNT_W-1:0]  new_length,
	output logic                       done,
	output logic                       ok,
	output logic                       found,
	output logic [ovl_pkg::IDX_W-1:0]  found_index,
	output logic [ovl_pkg::DATA_W-1:0] read_value,
	output logic [ovl_pkg::CNT_W-1:0]  length
);
	import ovl_pkg::*;

	logic                    accept;
	logic [CNT_W-1:0]        count_q;
	logic [CNT_W-1:0]        count_next;
	logic                    ok_next;
	logic                    append_ok;
	logic                    insert_ok;
	logic                    read_ok;
	logic                    resize_ok;
	logic                    find_hit;
	logic [IDX_W-1:0]        find_idx;
	logic [DATA_W-1:0]       entries   [CAPACITY];
	logic [CAPACITY-1:0]     match;
	logic [CAPACITY-1:0]     hits;

	logic                    done_q;
	logic                    ok_q;
	logic                    found_q;
	logic [IDX_W-1:0]        found_index_q;
	logic [DATA_W-1:0]       read_value_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Range and capacity checks for the incoming item.
	assign append_ok = (count_q < CNT_W'(CAPACITY));
	assign insert_ok = (position <= count_q) && (count_q < CNT_W'(CAPACITY));
	assign read_ok   = (position < count_q);
	assign resize_ok = (new_length <= CNT_W'(CAPACITY));

	// Outcome and new length of the item.
	always_comb begin
		ok_next    = 1'b0;
		count_next = count_q;
		case (act_t'(action))
			ACT_APPEND: begin
				ok_next = append_ok;
				if (append_ok) count_next = count_q + CNT_W'(1);
			end
			ACT_INSERT: begin
				ok_next = insert_ok;
				if (insert_ok) count_next = count_q + CNT_W'(1);
			end
			ACT_FIND: begin
				ok_next = 1'b1;
			end
			ACT_READ: begin
				ok_next = read_ok;
			end
			ACT_RESIZE: begin
				ok_next = resize_ok;
				if (resize_ok) count_next = new_length;
			end
			default: begin
				ok_next = 1'b0;
			end
		endcase
	end

	// Per-cell control and the row of cells.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [CNT_W-1:0]  pos_c;
		logic [DATA_W-1:0] left_c;
		cell_ctrl_t        ctrl_c;

		assign pos_c = CNT_W'(i);

		always_comb begin
			ctrl_c.op = CELL_HOLD;
			if (accept) begin
				case (act_t'(action))
					ACT_APPEND: begin
						if (append_ok && pos_c == count_q) ctrl_c.op = CELL_LOAD;
					end
					ACT_INSERT: begin
						if (insert_ok) begin
							if (pos_c == position) begin
								ctrl_c.op = CELL_LOAD;
							end else if (pos_c > position && pos_c <= count_q) begin
								ctrl_c.op = CELL_SHIFT;
							end
						end
					end
					ACT_RESIZE: begin
						if (resize_ok && pos_c >= count_q && pos_c < new_length) begin
							ctrl_c.op = CELL_ZERO;
						end
					end
					default: begin
						ctrl_c.op = CELL_HOLD;
					end
				endcase
			end
		end

		if (i == 0) begin : g_first
			assign left_c = '0;
		end else begin : g_rest
			assign left_c = entries[i-1];
		end

		ovl_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl_c),
			.load_value (value),
			.left_entry (left_c),
			.key        (value),
			.entry      (entries[i]),
			.match      (match[i])
		);

		// Only cells inside the current length take part in a search.
		assign hits[i] = match[i] && (pos_c < count_q);
	end

	ovl_find u_find (
		.hits  (hits),
		.found (find_hit),
		.index (find_idx)
	);

	// Length and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= accept;
			if (accept) count_q <= count_next;
		end
	end

	// Result payload, captured at the accept edge.
	always_ff @(posedge clk) begin
		if (accept) begin
			ok_q          <= ok_next;
			found_q       <= (act_t'(action) == ACT_FIND) && find_hit;
			found_index_q <= (act_t'(action) == ACT_FIND && find_hit) ? find_idx : '0;
			read_value_q  <= (act_t'(action) == ACT_READ && read_ok)
				? entries[position[IDX_W-1:0]] : '0;
		end
	end

	assign done        = done_q;
	assign ok          = ok_q;
	assign found       = found_q;
	assign found_index = found_index_q;
	assign read_value  = read_value_q;
	assign length      = count_q;

	// A result is only shown in the cycle after an accepted item.
	a_done_follows_accept: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy))
		else $error("result strobe without an accepted item");

	// A rejected item leaves the length alone.
	a_reject_keeps_length: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !ok) |-> (length == $past(length)))
		else $error("rejected item changed the length");

	// A match is never reported for a failed item, and a miss reports index zero.
	a_found_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !found) |-> (found_index == '0))
		else $error("nonzero index without a match");

	a_found_implies_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && found) |-> ok)
		else $error("match reported on a rejected item");

	// The length never passes the capacity.
	a_length_bound: assert property (@(posedge clk) disable iff (!arst_n)
		length <= CNT_W'(CAPACITY))
		else $error("length exceeds capacity");

endmodule

[rtl/core/ovl_cell.sv]
// One cell of the list: holds one entry, loads, takes its left neighbor or clears.
// Depends on ovl_pkg.

module ovl_cell (
	input  logic                       clk,
	input  ovl_pkg::cell_ctrl_t        ctrl,
	input  logic [ovl_pkg::DATA_W-1:0] load_value,
	input  logic [ovl_pkg::DATA_W-1:0] left_entry,
	input  logic [ovl_pkg::DATA_W-1:0] key,
	output logic [ovl_pkg::DATA_W-1:0] entry,
	output logic                       match
);
	import ovl_pkg::*;

	logic [DATA_W-1:0] entry_q;

	// Entry update; the entry carries no reset since only written cells are read.
	always_ff @(posedge clk) begin
		case (ctrl.op)
			CELL_LOAD:  entry_q <= load_value;
			CELL_SHIFT: entry_q <= left_entry;
			CELL_ZERO:  entry_q <= '0;
			default:    entry_q <= entry_q;
		endcase
	end

	// Local compare against the broadcast search key.
	assign match = (entry_q == key);
	assign entry = entry_q;

endmodule

[rtl/core/ovl_find.sv]
// First-match encoder over the per-cell match flags.
// Depends on ovl_pkg.

module ovl_find (
	input  logic [ovl_pkg::CAPACITY-1:0] hits,
	output logic                         found,
	output logic [ovl_pkg::IDX_W-1:0]    index
);
	import ovl_pkg::*;

	// Scan from the top so the lowest hit wins.
	always_comb begin
		index = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (hits[i]) begin
				index = IDX_W'(i);
			end
		end
	end

	assign found = |hits;

endmodule

[tb/tb.sv]
// Testbench for ordered_value_list: directed and random list actions, each result checked
// against a mirror of the list kept in a small scoreboard class. Depends on ovl_pkg and the RTL.

module tb;

	import ovl_pkg::*;

	// Action codes that the block does not define; they must be rejected.
	localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd5;
	localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;

	localparam int RANDOM_ITEMS = 1300;
	localparam int QUIET_LIMIT  = 2000;
	localparam int IDLE_PCT     = 7;

	// One result item as the block reports it.
	typedef struct packed {
		logic              ok;
		logic              found;
		logic [IDX_W-1:0]  found_index;
		logic [DATA_W-1:0] read_value;
		logic [CNT_W-1:0]  length;
	} list_result_t;

	// Mirror of the list contents and the results owed by the block.
	class list_mirror;
		logic [DATA_W-1:0] mirror_entries [CAPACITY];
		int unsigned       mirror_len;
		list_result_t      outcomes_due [$];
		int                errors;

		function new();
			mirror_len = 0;
			errors = 0;
		endfunction

		// Apply one action to the mirror and return the result it should produce.
		function list_result_t perform(logic [ACT_W-1:0] act, logic [CNT_W-1:0] pos,
			logic [DATA_W-1:0] val, logic [CNT_W-1:0] nlen);
			list_result_t r;
			int i;
			r = '0;
			case (act)
				ACT_APPEND: begin
					if (mirror_len < CAPACITY) begin
						mirror_entries[mirror_len] = val;
						mirror_len++;
						r.ok = 1'b1;
					end
				end
				ACT_INSERT: begin
					if (pos <= mirror_len && mirror_len < CAPACITY) begin
						for (i = mirror_len; i > pos; i--)
							mirror_entries[i] = mirror_entries[i-1];
						mirror_entries[pos] = val;
						mirror_len++;
						r.ok = 1'b1;
					end
				end
				ACT_FIND: begin
					r.ok = 1'b1;
					for (i = 0; i < mirror_len; i++) begin
						if (!r.found && mirror_entries[i] == val) begin
							r.found = 1'b1;
							r.found_index = i[IDX_W-1:0];
						end
					end
				end
				ACT_READ: begin
					if (pos < mirror_len) begin
						r.read_value = mirror_entries[pos];
						r.ok = 1'b1;
					end
				end
				ACT_RESIZE: begin
					if (nlen <= CAPACITY) begin
						for (i = mirror_len; i < nlen; i++)
							mirror_entries[i] = '0;
						mirror_len = 32'(nlen);
						r.ok = 1'b1;
					end
				end
				default: begin
				end
			endcase
			r.length = mirror_len[CNT_W-1:0];
			return r;
		endfunction

		// Record an accepted item and queue the result it owes.
		function void note_command(logic [ACT_W-1:0] act, logic [CNT_W-1:0] pos,
			logic [DATA_W-1:0] val, logic [CNT_W-1:0] nlen);
			list_result_t owed;
			owed = perform(act, pos, val, nlen);
			outcomes_due.insert(outcomes_due.size(), owed);
		endfunction

		function void compare_field(string name, logic [DATA_W-1:0] exp_v,
			logic [DATA_W-1:0] got_v);
			if (exp_v !== got_v) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
				errors++;
			end
		endfunction

		// Compare a result from the block with the oldest one owed.
		function void check_result(list_result_t got);
			list_result_t exp_r;
			if (outcomes_due.size() == 0) begin
				$display("%0t: result with nothing owed, actual %0h", $time, got);
				errors++;
				return;
			end
			exp_r = outcomes_due.pop_front();
			compare_field("ok", DATA_W'(exp_r.ok), DATA_W'(got.ok));
			compare_field("found", DATA_W'(exp_r.found), DATA_W'(got.found));
			compare_field("found_index", DATA_W'(exp_r.found_index), DATA_W'(got.found_index));
			compare_field("read_value", exp_r.read_value, got.read_value);
			compare_field("length", DATA_W'(exp_r.length), DATA_W'(got.length));
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic [ACT_W-1:0]  action = '0;
	logic [CNT_W-1:0]  position = '0;
	logic [DATA_W-1:0] value = '0;
	logic [CNT_W-1:0]  new_length = '0;
	logic              done;
	logic              ok;
	logic              found;
	logic [IDX_W-1:0]  found_index;
	logic [DATA_W-1:0] read_value;
	logic [CNT_W-1:0]  length;

	list_mirror mirror = new();
	bit         idle_on = 1'b1;

	ordered_value_list i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.action     (action),
		.position   (position),
		.value      (value),
		.new_length (new_length),
		.done       (done),
		.ok         (ok),
		.found      (found),
		.found_index(found_index),
		.read_value (read_value),
		.length     (length)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Every result is taken at the edge that ends its strobe cycle.
	always @(posedge clk) begin
		if (done)
			mirror.check_result({ok, found, found_index, read_value, length});
	end

	// Ends the run if neither an item nor a result moves for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || done)
				quiet = 0;
			else
				quiet++;
		end
		$display("simulation failed");
		$finish;
	end

	// Mix of extremes, small values that repeat, and fully random words.
	function automatic logic [DATA_W-1:0] pick_value();
		logic [DATA_W-1:0] v;
		case ($urandom_range(0, 9))
			0: v = 32'h7fff_ffff;
			1: v = 32'h8000_0000;
			2: v = '0;
			3: v = '1;
			4, 5, 6: v = $urandom_range(0, 7);
			default: v = $urandom;
		endcase
		return v;
	endfunction

	// Offer one item, with random idle cycles first, and wait until it is taken.
	task automatic send_item(input logic [ACT_W-1:0] act, input logic [CNT_W-1:0] pos,
		input logic [DATA_W-1:0] val, input logic [CNT_W-1:0] nlen);
		while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
			start <= 1'b0;
			action <= ACT_W'($urandom);
			value <= $urandom;
			@(posedge clk);
		end
		start <= 1'b1;
		action <= act;
		position <= pos;
		value <= val;
		new_length <= nlen;
		do
			@(posedge clk);
		while (busy);
		mirror.note_command(act, pos, val, nlen);
	endtask

	initial begin
		int n;
		int roll;
		int unsigned len;
		int a;
		logic [ACT_W-1:0]  act;
		logic [CNT_W-1:0]  pos;
		logic [DATA_W-1:0] val;
		logic [CNT_W-1:0]  nlen;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: empty list, insert at the front, out-of-range positions,
		// extremes, duplicates, full list, resize limits and the unused codes.
		send_item(ACT_FIND, 5'd0, 32'd5, 5'd0);
		send_item(ACT_READ, 5'd0, 32'd0, 5'd0);
		send_item(ACT_INSERT, 5'd0, 32'd5, 5'd0);
		send_item(ACT_INSERT, 5'd2, 32'd9, 5'd0);
		send_item(ACT_APPEND, 5'd0, 32'h7fff_ffff, 5'd0);
		send_item(ACT_APPEND, 5'd0, 32'h8000_0000, 5'd0);
		send_item(ACT_INSERT, 5'd1, 32'hffff_ffff, 5'd0);
		send_item(ACT_INSERT, 5'd4, 32'd5, 5'd0);
		send_item(ACT_FIND, 5'd0, 32'd5, 5'd0);
		send_item(ACT_FIND, 5'd0, 32'h8000_0000, 5'd0);
		send_item(ACT_FIND, 5'd0, 32'd1234, 5'd0);
		send_item(ACT_READ, 5'd4, 32'd0, 5'd0);
		send_item(ACT_READ, 5'd5, 32'd0, 5'd0);
		send_item(ACT_READ, 5'd31, 32'd0, 5'd0);
		send_item(ACT_INSERT, 5'd31, 32'd7, 5'd0);
		send_item(ACT_RESIZE, 5'd0, 32'd0, 5'd0);
		send_item(ACT_FIND, 5'd0, 32'd0, 5'd0);
		send_item(ACT_RESIZE, 5'd0, 32'd0, CAPACITY[CNT_W-1:0]);
		send_item(ACT_APPEND, 5'd0, 32'd1, 5'd0);
		send_item(ACT_INSERT, 5'd0, 32'd1, 5'd0);
		send_item(ACT_READ, 5'd15, 32'd0, 5'd0);
		send_item(ACT_RESIZE, 5'd0, 32'd0, 5'd17);
		send_item(ACT_RESIZE, 5'd0, 32'd0, 5'd31);
		send_item(ACT_RESIZE, 5'd0, 32'd0, 5'd3);
		for (a = ACT_SPARE_LO; a <= ACT_SPARE_HI; a++)
			send_item(a[ACT_W-1:0], CNT_W'($urandom), $urandom, CNT_W'($urandom));

		// Random part, shaped so that the list swings between empty and full.
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			idle_on = !(n >= 500 && n < 800);
			roll = $urandom_range(0, 99);
			len = mirror.mirror_len;
			pos = CNT_W'($urandom_range(0, 31));
			val = pick_value();
			nlen = CNT_W'($urandom_range(0, 31));
			if (roll < 20) begin
				act = ACT_APPEND;
			end else if (roll < 40) begin
				act = ACT_INSERT;
				if ($urandom_range(0, 3) != 0)
					pos = CNT_W'($urandom_range(0, len));
			end else if (roll < 60) begin
				act = ACT_FIND;
				if (len > 0 && $urandom_range(0, 1) == 1)
					val = mirror.mirror_entries[$urandom_range(0, len - 1)];
			end else if (roll < 80) begin
				act = ACT_READ;
				if (len > 0 && $urandom_range(0, 3) != 0)
					pos = CNT_W'($urandom_range(0, len - 1));
			end else if (roll < 96) begin
				act = ACT_RESIZE;
				if ($urandom_range(0, 3) != 0)
					nlen = CNT_W'($urandom_range(0, CAPACITY));
			end else begin
				act = ACT_W'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
			end
			send_item(act, pos, val, nlen);
		end
		start <= 1'b0;

		// Drain the outstanding results, then allow a few more cycles for strays.
		while (mirror.outcomes_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		if (mirror.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

[filelist.f]
rtl/core/ovl_pkg.sv
rtl/core/ovl_cell.sv
rtl/core/ovl_find.sv
rtl/core/ordered_value_list.sv
tb/tb.sv
